// File: rtl/core/min_window_cover_finder_defines.svh
// ----------------------------------------------------------------------------
// min_window_cover_finder_defines.svh
// Assertion macros shared by the cover finder modules.
// ----------------------------------------------------------------------------
`ifndef MIN_WINDOW_COVER_FINDER_DEFINES_SVH
`define MIN_WINDOW_COVER_FINDER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MWCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define MWCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mwcf_pkg.sv
// ----------------------------------------------------------------------------
// mwcf_pkg
// Sizes, operation word and status types of the minimum window cover finder.
// ----------------------------------------------------------------------------
package mwcf_pkg;

    localparam int MAX_TEXT    = 4096;
    localparam int MAX_PATTERN = 256;
    localparam int ALPHA       = 256;

    localparam int TEXT_IDX_W = $clog2(MAX_TEXT);
    localparam int TEXT_CNT_W = $clog2(MAX_TEXT + 1);
    localparam int PAT_CNT_W  = $clog2(MAX_PATTERN + 1);
    localparam int NEED_W     = TEXT_CNT_W;
    localparam int CH_W       = $clog2(ALPHA);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued operation for the back end
    typedef struct packed {
        logic            is_text;   // 0: pattern byte, 1: text byte
        logic            scan;      // text byte within capacity
        logic            last;      // ends the job
        logic            drop;      // job dropped bytes (valid with last)
        logic [CH_W-1:0] ch;
    } mwcf_op_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        mwcf_op_t op;
    } mwcf_head_t;

endpackage

// File: rtl/core/mwcf_item_if.sv
// ----------------------------------------------------------------------------
// mwcf_item_if
// Valid/ready channels: input words and result words.
// ----------------------------------------------------------------------------
interface mwcf_item_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [mwcf_pkg::CH_W-1:0]   ch;
    logic                        last;

    modport source (output valid, output func, output ch, output last, input ready);
    modport sink   (input valid, input func, input ch, input last, output ready);
endinterface

interface mwcf_result_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [mwcf_pkg::TEXT_IDX_W-1:0] window_start;
    logic [mwcf_pkg::TEXT_CNT_W-1:0] window_len;
    logic                            overflow;

    modport source (output valid, output found, output window_start, output window_len,
                    output overflow, input ready);
    modport sink   (input valid, input found, input window_start, input window_len,
                    input overflow, output ready);
endinterface

// File: rtl/core/min_window_cover_finder.sv
// ----------------------------------------------------------------------------
// min_window_cover_finder
// Shortest text window that covers every byte of a pattern, with multiplicity.
// ----------------------------------------------------------------------------
// Send the pattern bytes first (func = 0), then the text bytes (func = 1);
// the text word with last set ends the job and yields one result word with
// found, window_start, window_len and overflow, after which the next job may
// begin straight away. A pattern byte passes through the states S_IDLE and
// S_PUPD, and a text byte through S_IDLE, S_RUPD and S_LCHK, plus S_LUPD
// and S_LCHK again for every step of the left edge, which moves at most once
// per text byte over a job; the result word is loaded in S_OUT. The pace of
// the scanner is set by the read-modify-write of the single
// need-count memory, which every right and left step passes through. A
// four-word queue sits between the input and the scanner, and a result
// register at the output, so input words keep flowing while a result waits.
// Up to MAX_PATTERN pattern bytes and MAX_TEXT text bytes are kept per job;
// surplus bytes are dropped and reported through overflow, and pattern bytes
// that follow the first text byte of a job are ignored. There is no clearing
// pass after reset: the need counts carry one valid flag per byte value.
// ----------------------------------------------------------------------------
module min_window_cover_finder
(
    input  logic          clk,
    input  logic          rst_n,
    mwcf_item_if.sink     item,
    mwcf_result_if.source result
);
    import mwcf_pkg::*;

    logic       q_full;
    logic       q_push;
    mwcf_op_t   q_op;
    logic       q_pop;
    mwcf_head_t q_head;

    // classify input words and enforce capacity
    mwcf_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_op)
    );

    // decouple the input from the scanner
    mwcf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    // scan the text and hold the result word
    mwcf_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .pop    (q_pop),
        .result (result)
    );

endmodule

// File: rtl/core/mwcf_front.sv
// ----------------------------------------------------------------------------
// mwcf_front
// Accept input words, apply capacity limits and queue operations.
// ----------------------------------------------------------------------------
module mwcf_front
(
    input  logic               clk,
    input  logic               rst_n,
    mwcf_item_if.sink          item,
    input  logic               q_full,
    output logic               q_push,
    output mwcf_pkg::mwcf_op_t q_op
);
    import mwcf_pkg::*;

    logic [PAT_CNT_W-1:0]  pat_cnt_reg, pat_cnt_next;
    logic [TEXT_CNT_W-1:0] txt_cnt_reg, txt_cnt_next;
    logic                  drop_reg, drop_next;
    logic                  accept;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        pat_cnt_next = pat_cnt_reg;
        txt_cnt_next = txt_cnt_reg;
        drop_next    = drop_reg;
        q_push       = 1'b0;
        q_op         = '0;
        q_op.ch      = item.ch;
        q_op.is_text = item.func;
        q_op.last    = item.last;
        if (accept)
        begin
            if (!item.func)
            begin
                // late pattern bytes are dropped silently
                q_op.last = 1'b0;
                if (txt_cnt_reg == '0)
                begin
                    if (pat_cnt_reg < PAT_CNT_W'(MAX_PATTERN))
                    begin
                        q_push       = 1'b1;
                        pat_cnt_next = pat_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            else
            begin
                q_op.scan = txt_cnt_reg < TEXT_CNT_W'(MAX_TEXT);
                if (q_op.scan)
                begin
                    txt_cnt_next = txt_cnt_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                q_op.drop = drop_next;
                q_push    = q_op.scan || item.last;
                if (item.last)
                begin
                    pat_cnt_next = '0;
                    txt_cnt_next = '0;
                    drop_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_cnt_reg <= '0;
            txt_cnt_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            pat_cnt_reg <= pat_cnt_next;
            txt_cnt_reg <= txt_cnt_next;
            drop_reg    <= drop_next;
        end
    end

endmodule

// File: rtl/core/mwcf_queue.sv
// ----------------------------------------------------------------------------
// mwcf_queue
// Short FIFO of operations between the front and back ends.
// ----------------------------------------------------------------------------
`include "min_window_cover_finder_defines.svh"

module mwcf_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mwcf_pkg::mwcf_op_t   push_op,
    output logic                 full,
    input  logic                 pop,
    output mwcf_pkg::mwcf_head_t head
);
    import mwcf_pkg::*;

    mwcf_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.op    = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MWCF_ASSERT_NOW(a_q_no_overrun, push, !full, "queue written while full")
    `MWCF_ASSERT_NOW(a_q_count_range, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/core/mwcf_back.sv
// ----------------------------------------------------------------------------
// mwcf_back
// Run the sliding window over the text store and need-count memory.
// ----------------------------------------------------------------------------
`include "min_window_cover_finder_defines.svh"

module mwcf_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mwcf_pkg::mwcf_head_t head,
    output logic                 pop,
    mwcf_result_if.source        result
);
    import mwcf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PUPD = 6'b000010,
        S_RUPD = 6'b000100,
        S_LCHK = 6'b001000,
        S_LUPD = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // storage
    logic signed [NEED_W-1:0] need_mem [ALPHA];
    logic [ALPHA-1:0]         need_vld_reg, need_vld_next;
    logic [CH_W-1:0]          text_mem [MAX_TEXT];

    logic                     need_rd_en;
    logic [CH_W-1:0]          need_rd_addr;
    logic signed [NEED_W-1:0] need_q;
    logic                     need_vld_q;
    logic                     need_wr_en;
    logic [CH_W-1:0]          need_wr_addr;
    logic signed [NEED_W-1:0] need_wr_data;
    logic signed [NEED_W-1:0] need_cur;
    logic signed [NEED_W-1:0] need_new;

    logic                     text_wr_en;
    logic [CH_W-1:0]          text_q;

    // job state
    logic [TEXT_CNT_W-1:0] left_reg, left_next;
    logic [TEXT_CNT_W-1:0] text_len_reg, text_len_next;
    logic [TEXT_IDX_W-1:0] right_reg, right_next;
    logic [PAT_CNT_W-1:0]  covered_reg, covered_next;
    logic [PAT_CNT_W-1:0]  pat_len_reg, pat_len_next;
    logic [TEXT_CNT_W-1:0] best_len_reg, best_len_next;
    logic [TEXT_IDX_W-1:0] best_start_reg, best_start_next;
    logic [CH_W-1:0]       cur_ch_reg, cur_ch_next;
    logic                  last_reg, last_next;
    logic                  drop_reg, drop_next;
    logic [TEXT_CNT_W-1:0] span;
    logic                  shrink;
    logic                  res_free;
    logic                  found;

    // result register
    logic                  res_valid_reg, res_valid_next;
    logic                  res_found_reg;
    logic [TEXT_IDX_W-1:0] res_start_reg;
    logic [TEXT_CNT_W-1:0] res_len_reg;
    logic                  res_ovf_reg;
    logic                  res_load;

    assign need_cur = need_vld_q ? need_q : '0;
    assign span     = {1'b0, right_reg} - left_reg + 1'b1;
    assign shrink   = (pat_len_reg != '0) && (covered_reg == pat_len_reg)
                      && (left_reg <= {1'b0, right_reg});
    assign res_free = !res_valid_reg || result.ready;
    assign found    = best_len_reg <= TEXT_CNT_W'(MAX_TEXT);

    always_comb
    begin
        state_next      = state_reg;
        pop             = 1'b0;
        need_rd_en      = 1'b0;
        need_rd_addr    = head.op.ch;
        need_wr_en      = 1'b0;
        need_wr_addr    = cur_ch_reg;
        need_new        = need_cur;
        need_wr_data    = need_cur;
        need_vld_next   = need_vld_reg;
        text_wr_en      = 1'b0;
        left_next       = left_reg;
        text_len_next   = text_len_reg;
        right_next      = right_reg;
        covered_next    = covered_reg;
        pat_len_next    = pat_len_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        cur_ch_next     = cur_ch_reg;
        last_next       = last_reg;
        drop_next       = drop_reg;
        res_load        = 1'b0;
        res_valid_next  = res_valid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    cur_ch_next = head.op.ch;
                    last_next   = head.op.last;
                    drop_next   = head.op.drop;
                    if (!head.op.is_text)
                    begin
                        need_rd_en = 1'b1;
                        state_next = S_PUPD;
                    end
                    else if (head.op.scan)
                    begin
                        // store the byte and fetch its need count
                        need_rd_en    = 1'b1;
                        text_wr_en    = 1'b1;
                        right_next    = text_len_reg[TEXT_IDX_W-1:0];
                        text_len_next = text_len_reg + 1'b1;
                        state_next    = S_RUPD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_PUPD:
            begin
                need_wr_en   = 1'b1;
                need_wr_data = need_cur + NEED_W'(1);
                pat_len_next = pat_len_reg + 1'b1;
                state_next   = S_IDLE;
            end
            S_RUPD:
            begin
                need_wr_en   = 1'b1;
                need_wr_data = need_cur - NEED_W'(1);
                if (need_cur > 0)
                begin
                    covered_next = covered_reg + 1'b1;
                end
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (shrink)
                begin
                    if (span < best_len_reg)
                    begin
                        best_len_next   = span;
                        best_start_next = left_reg[TEXT_IDX_W-1:0];
                    end
                    // fetch the count of the byte leaving the window
                    cur_ch_next  = text_q;
                    need_rd_en   = 1'b1;
                    need_rd_addr = text_q;
                    state_next   = S_LUPD;
                end
                else
                begin
                    state_next = last_reg ? S_OUT : S_IDLE;
                end
            end
            S_LUPD:
            begin
                need_new     = need_cur + NEED_W'(1);
                need_wr_en   = 1'b1;
                need_wr_data = need_new;
                if (need_new > 0)
                begin
                    covered_next = covered_reg - 1'b1;
                end
                left_next  = left_reg + 1'b1;
                state_next = S_LCHK;
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    res_load        = 1'b1;
                    res_valid_next  = 1'b1;
                    // clear the job
                    need_vld_next   = '0;
                    left_next       = '0;
                    text_len_next   = '0;
                    covered_next    = '0;
                    pat_len_next    = '0;
                    best_len_next   = TEXT_CNT_W'(MAX_TEXT + 1);
                    best_start_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (need_wr_en && !res_load)
        begin
            need_vld_next[need_wr_addr] = 1'b1;
        end
    end

    // need-count memory: one read, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (need_rd_en)
        begin
            need_q     <= need_mem[need_rd_addr];
            need_vld_q <= need_vld_reg[need_rd_addr];
        end
        if (need_wr_en)
        begin
            need_mem[need_wr_addr] <= need_wr_data;
        end
    end

    // text store: always read at the next left edge
    always_ff @(posedge clk)
    begin
        text_q <= text_mem[left_next[TEXT_IDX_W-1:0]];
        if (text_wr_en)
        begin
            text_mem[text_len_reg[TEXT_IDX_W-1:0]] <= head.op.ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_found_reg <= found;
            res_start_reg <= found ? best_start_reg : '0;
            res_len_reg   <= found ? best_len_reg : '0;
            res_ovf_reg   <= drop_reg;
        end
        cur_ch_reg <= cur_ch_next;
        last_reg   <= last_next;
        drop_reg   <= drop_next;
        right_reg  <= right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            need_vld_reg   <= '0;
            left_reg       <= '0;
            text_len_reg   <= '0;
            covered_reg    <= '0;
            pat_len_reg    <= '0;
            best_len_reg   <= TEXT_CNT_W'(MAX_TEXT + 1);
            best_start_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            need_vld_reg   <= need_vld_next;
            left_reg       <= left_next;
            text_len_reg   <= text_len_next;
            covered_reg    <= covered_next;
            pat_len_reg    <= pat_len_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.found        = res_found_reg;
    assign result.window_start = res_start_reg;
    assign result.window_len   = res_len_reg;
    assign result.overflow     = res_ovf_reg;

    `MWCF_ASSERT_NOW(a_covered_bound, 1'b1, covered_reg <= pat_len_reg, "covered exceeds pattern length")
    `MWCF_ASSERT_NOW(a_left_bound, 1'b1, left_reg <= text_len_reg, "left edge beyond text")
    `MWCF_ASSERT_NEXT(a_job_cleared, (state_reg == S_OUT) && res_free, (text_len_reg == '0) && result.valid, "job not cleared on result")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the minimum window cover finder word by word. Pattern and text words
// go in over the item channel with random gaps; every result word is compared
// with the oldest pending prediction. The predictor below keeps its own need
// counts, text copy and window bookkeeping. A short directed table covers the
// corner cases first, then random jobs of small pattern and text sizes follow.
// ----------------------------------------------------------------------------
module testbench;

    import mwcf_pkg::*;

    // Operation carried by the func bit of an input word
    localparam bit FUNC_PATTERN = 1'b0;
    localparam bit FUNC_TEXT    = 1'b1;

    localparam int RANDOM_WORDS = 1800;
    localparam int MAX_PAUSE    = 16;
    // Wait after the last result, long enough for any stray result word to show
    localparam int SETTLE       = 64;
    // Several times the slowest legal run, at 4 ns a cycle
    localparam int LIMIT_NS     = 4_800_000;
    localparam int REPORT_MAX   = 10;

    // One result word as the block reports it
    typedef struct packed {
        logic                  found;
        logic [TEXT_IDX_W-1:0] start;
        logic [TEXT_CNT_W-1:0] len;
        logic                  overflow;
    } cover_t;

    // One row of the directed table: a word repeated reps times, last only on
    // the final repeat, with the result typed in where it is plain to read
    typedef struct packed {
        logic        func;
        logic [7:0]  ch;
        logic        last;
        logic [12:0] reps;
        logic        typed;
        cover_t      exp;
    } plan_row_t;

    localparam cover_t NONE = '0;

    localparam int PLAN_ROWS = 29;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // empty pattern: nothing can ever cover
        '{FUNC_TEXT,    8'h41, 1'b1, 13'd1,    1'b1, '{1'b0, 12'd0,    13'd0,    1'b0}},
        // lowest byte value, one-byte match
        '{FUNC_PATTERN, 8'h00, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h00, 1'b1, 13'd1,    1'b1, '{1'b1, 12'd0,    13'd1,    1'b0}},
        // highest byte value, repeated in the pattern
        '{FUNC_PATTERN, 8'hFF, 1'b0, 13'd2,    1'b0, NONE},
        '{FUNC_TEXT,    8'h12, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'hFF, 1'b1, 13'd2,    1'b1, '{1'b1, 12'd1,    13'd2,    1'b0}},
        // pattern word arriving after the text has begun
        '{FUNC_PATTERN, 8'h55, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h55, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_PATTERN, 8'hAA, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h33, 1'b1, 13'd1,    1'b0, NONE},
        // last flag on a pattern word
        '{FUNC_PATTERN, 8'h10, 1'b1, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h10, 1'b1, 13'd1,    1'b0, NONE},
        // text shorter than the pattern
        '{FUNC_PATTERN, 8'h01, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_PATTERN, 8'h02, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_PATTERN, 8'h03, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h01, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h02, 1'b1, 13'd1,    1'b1, '{1'b0, 12'd0,    13'd0,    1'b0}},
        // pattern one past capacity
        '{FUNC_PATTERN, 8'h61, 1'b0, 13'd257,  1'b0, NONE},
        '{FUNC_TEXT,    8'h61, 1'b1, 13'd256,  1'b1, '{1'b1, 12'd0,    13'd256,  1'b1}},
        // text full, match in the final slot, surplus last word dropped
        '{FUNC_PATTERN, 8'hC3, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h5A, 1'b0, 13'd4095, 1'b0, NONE},
        '{FUNC_TEXT,    8'hC3, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h11, 1'b1, 13'd1,    1'b1, '{1'b1, 12'd4095, 13'd1,    1'b1}},
        // widest window: the whole text buffer
        '{FUNC_PATTERN, 8'h01, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_PATTERN, 8'h02, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h01, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h00, 1'b0, 13'd4094, 1'b0, NONE},
        '{FUNC_TEXT,    8'h02, 1'b0, 13'd1,    1'b0, NONE},
        '{FUNC_TEXT,    8'h02, 1'b1, 13'd1,    1'b1, '{1'b1, 12'd0,    13'd4096, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    mwcf_item_if   item_bus ();
    mwcf_result_if result_bus ();

    min_window_cover_finder dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Window predictor state
    // ------------------------------------------------------------------------
    int         demand [256];        // outstanding need per byte value, signed
    logic [7:0] text_mem [MAX_TEXT]; // text of the current job
    int         lo;                  // left edge of the window
    int         n_text;              // text bytes kept
    int         n_hit;               // pattern bytes currently covered
    int         n_pat;               // pattern bytes kept
    int         short_len;           // shortest window so far, MAX_TEXT+1 if none
    int         short_at;
    bit         spilled;             // a byte was dropped this job

    cover_t     pending_covers [$];  // predicted result words, oldest first
    int         n_bad = 0;
    int         words_sent = 0;
    bit         src_calm = 1'b0;
    bit         snk_calm = 1'b0;
    logic [7:0] sym [4];             // small alphabet of the current random job

    // Clear every per-job count for the next job
    function automatic void open_job();
        foreach (demand[i])
            demand[i] = 0;
        lo        = 0;
        n_text    = 0;
        n_hit     = 0;
        n_pat     = 0;
        short_len = MAX_TEXT + 1;
        short_at  = 0;
        spilled   = 1'b0;
    endfunction

    // Advance the predictor by one accepted word; return 1 with the result
    // word when the word closes the job
    function automatic bit predict_word(input bit f, input logic [7:0] c,
                                        input bit l, output cover_t res);
        int         right;
        int         span;
        logic [7:0] gone;
        res = '0;
        if (f == FUNC_PATTERN) begin
            // drop pattern words once the text has started
            if (n_text == 0) begin
                if (n_pat < MAX_PATTERN) begin
                    demand[c]++;
                    n_pat++;
                end
                else begin
                    spilled = 1'b1;
                end
            end
            return 1'b0;
        end
        if (n_text < MAX_TEXT) begin
            right           = n_text;
            text_mem[right] = c;
            n_text++;
            if (demand[c] > 0)
                n_hit++;
            demand[c]--;
            // shrink from the left while the window still covers the pattern
            while (n_pat > 0 && n_hit == n_pat && lo <= right) begin
                span = right - lo + 1;
                if (span < short_len) begin
                    short_len = span;
                    short_at  = lo;
                end
                gone = text_mem[lo];
                demand[gone]++;
                if (demand[gone] > 0)
                    n_hit--;
                lo++;
            end
        end
        else begin
            spilled = 1'b1;
        end
        if (!l)
            return 1'b0;
        res.found = (short_len <= MAX_TEXT);
        if (res.found) begin
            res.start = short_at[TEXT_IDX_W-1:0];
            res.len   = short_len[TEXT_CNT_W-1:0];
        end
        res.overflow = spilled;
        open_job();
        return 1'b1;
    endfunction

    function automatic int pause(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    task automatic flag_bad(input string msg);
        n_bad++;
        if (n_bad <= REPORT_MAX)
            $display("%0t: %s", $time, msg);
    endtask

    // Offer one word after a random gap, hold it until accepted, then predict.
    // A typed expectation, where given, stands in for the predicted one.
    task automatic send_word(input bit f, input logic [7:0] c, input bit l,
                             input bit use_given, input cover_t given);
        int     gap;
        cover_t got;
        gap = pause(src_calm);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.func  <= f;
        item_bus.ch    <= c;
        item_bus.last  <= l;
        do
            @(posedge clk);
        while (!item_bus.ready);
        words_sent++;
        if (predict_word(f, c, l, got))
            pending_covers.push_back(use_given ? given : got);
    endtask

    // Mostly bytes from the job's small alphabet so that windows form often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) < 85)
            return sym[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, then check each accepted word against the
    // oldest prediction
    // ------------------------------------------------------------------------
    initial
    begin
        int     stall;
        cover_t want;
        cover_t seen;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                snk_calm = ~snk_calm;
            stall = pause(snk_calm);
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
            seen.found    = result_bus.found;
            seen.start    = result_bus.window_start;
            seen.len      = result_bus.window_len;
            seen.overflow = result_bus.overflow;
            if (pending_covers.size() == 0) begin
                flag_bad($sformatf("result word with none pending: found=%0d start=%0d len=%0d ovf=%0d",
                                   seen.found, seen.start, seen.len, seen.overflow));
            end
            else begin
                want = pending_covers.pop_front();
                if (seen.found !== want.found || seen.start !== want.start ||
                    seen.len !== want.len || seen.overflow !== want.overflow)
                    flag_bad($sformatf({"mismatch: expected found=%0d start=%0d len=%0d ovf=%0d,",
                                        " got found=%0d start=%0d len=%0d ovf=%0d"},
                                       want.found, want.start, want.len, want.overflow,
                                       seen.found, seen.start, seen.len, seen.overflow));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random jobs
    // ------------------------------------------------------------------------
    initial
    begin
        int pat_n;
        int txt_n;
        int pick;
        bit lastb;
        item_bus.valid <= 1'b0;
        item_bus.func  <= FUNC_PATTERN;
        item_bus.ch    <= 8'h00;
        item_bus.last  <= 1'b0;
        rst_n          <= 1'b0;
        open_job();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; gaps stay random, so the long rows also
        // give the scanner plenty of back-pressure phases
        for (int r = 0; r < PLAN_ROWS; r++) begin
            for (int k = 0; k < int'(PLAN[r].reps); k++) begin
                lastb = PLAN[r].last && (k == int'(PLAN[r].reps) - 1);
                send_word(PLAN[r].func, PLAN[r].ch, lastb, PLAN[r].typed, PLAN[r].exp);
            end
        end

        // Random jobs: small patterns and texts mostly over a four-byte alphabet,
        // sprinkled with late pattern words and stray last flags on pattern
        // words; every job closes with a last text word
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            src_calm = ($urandom_range(0, 4) == 0);
            foreach (sym[i])
                sym[i] = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 15);
            if (pick == 0)
                pat_n = 0;
            else if (pick < 12)
                pat_n = $urandom_range(1, 5);
            else
                pat_n = $urandom_range(6, 24);
            txt_n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 30);
            for (int k = 0; k < pat_n; k++)
                send_word(FUNC_PATTERN, pick_byte(), ($urandom_range(0, 9) == 0),
                          1'b0, NONE);
            for (int k = 0; k < txt_n; k++) begin
                if (k > 0 && $urandom_range(0, 19) == 0)
                    send_word(FUNC_PATTERN, pick_byte(), 1'($urandom_range(0, 1)), 1'b0, NONE);
                send_word(FUNC_TEXT, pick_byte(), (k == txt_n - 1), 1'b0, NONE);
            end
        end
        item_bus.valid <= 1'b0;

        // Drain, then give the block time to show any stray result word
        while (pending_covers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_covers.size() != 0)
            flag_bad($sformatf("%0d result words never arrived", pending_covers.size()));

        if (n_bad == 0)
            $display("min_window_cover_finder test passed");
        else
            $display("min_window_cover_finder test failed");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #(LIMIT_NS);
        $display("min_window_cover_finder test failed");
        $finish;
    end

endmodule
